// File: hdl/mti_pkg.sv
// ----------------------------------------------------------------------------
// mti_pkg: shared types and constants for the motion tween interpolator
// Widths, stream packing, mode codes and the lane request/response structs.
// ----------------------------------------------------------------------------
package mti_pkg;

	localparam int COORD_BITS = 16;
	localparam int TIME_BITS  = 16;

	// per-lane arithmetic widths
	localparam int MAG_BITS  = COORD_BITS + 1;      // |target - start|
	localparam int QUO_BITS  = COORD_BITS + 1;      // quotient never exceeds the magnitude
	localparam int NUM_BITS  = 2 * TIME_BITS + 1;   // t, t*t or 2*u*u
	localparam int DEN_BITS  = 2 * TIME_BITS;       // D or D*D
	localparam int PROD_BITS = MAG_BITS + NUM_BITS;
	localparam int CNT_BITS  = $clog2(QUO_BITS + 1);

	// stream packing
	localparam int IN_FIELD_BITS  = 2 * COORD_BITS + TIME_BITS + 2;
	localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
	localparam int OUT_FIELD_BITS = 2 * COORD_BITS + 1;
	localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

	localparam int DX_LSB   = 0;
	localparam int DY_LSB   = COORD_BITS;
	localparam int DUR_LSB  = 2 * COORD_BITS;
	localparam int MODE_LSB = 2 * COORD_BITS + TIME_BITS;
	localparam int MOV_BIT  = 2 * COORD_BITS;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_MOVE = 1'b1;

	typedef enum logic [1:0] {
		MODE_HOLD        = 2'd0,
		MODE_LINEAR      = 2'd1,
		MODE_EASE_IN     = 2'd2,
		MODE_EASE_IN_OUT = 2'd3
	} mode_t;

	typedef struct packed {
		logic                go;
		logic [NUM_BITS-1:0] num;
		logic [DEN_BITS-1:0] den;
		logic                from_end;   // offset is taken back from the target
	} lane_req_t;

	typedef struct packed {
		logic                         done;
		logic signed [COORD_BITS-1:0] pos;
	} lane_rsp_t;

endpackage

// File: hdl/mti_lane.sv
// ----------------------------------------------------------------------------
// mti_lane: one axis of the tween
// Scales |target - start| by num, divides by den with a restoring divider
// (one quotient bit per cycle) and applies the signed offset.
// ----------------------------------------------------------------------------
module mti_lane (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  mti_pkg::lane_req_t                     req,
	input  logic signed [mti_pkg::COORD_BITS-1:0]  start_pos,
	input  logic signed [mti_pkg::COORD_BITS-1:0]  end_pos,
	output mti_pkg::lane_rsp_t                     rsp
);

	typedef enum logic [3:0] {
		L_IDLE = 4'b0001,
		L_LOAD = 4'b0010,
		L_DIV  = 4'b0100,
		L_DONE = 4'b1000
	} lstate_t;

	lstate_t                         lstate_q;
	logic [mti_pkg::MAG_BITS-1:0]    dlt;
	logic [mti_pkg::MAG_BITS-1:0]    mag;
	logic [mti_pkg::PROD_BITS-1:0]   prod_s1;
	logic                            neg_q;
	logic                            from_end_q;
	logic [mti_pkg::DEN_BITS-1:0]    den_q;
	logic [mti_pkg::DEN_BITS-1:0]    rem_q;
	logic [mti_pkg::QUO_BITS-1:0]    quo_q;
	logic [mti_pkg::CNT_BITS-1:0]    cnt_q;
	logic [mti_pkg::DEN_BITS:0]      trial;
	logic [mti_pkg::DEN_BITS:0]      trial_sub;
	logic                            take;
	logic [mti_pkg::COORD_BITS+1:0]  q_ext;
	logic [mti_pkg::COORD_BITS+1:0]  offs;

	assign dlt = {end_pos[mti_pkg::COORD_BITS-1], end_pos}
		- {start_pos[mti_pkg::COORD_BITS-1], start_pos};
	assign mag = dlt[mti_pkg::MAG_BITS-1] ? (~dlt + 1'b1) : dlt;

	assign trial     = {rem_q, quo_q[mti_pkg::QUO_BITS-1]};
	assign trial_sub = trial - {1'b0, den_q};
	assign take      = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lstate_q <= L_IDLE;
			cnt_q    <= '0;
		end else begin
			unique case (lstate_q)
				L_IDLE: begin
					if (req.go) lstate_q <= L_LOAD;
				end
				L_LOAD: begin
					cnt_q    <= mti_pkg::CNT_BITS'(mti_pkg::QUO_BITS);
					lstate_q <= L_DIV;
				end
				L_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == mti_pkg::CNT_BITS'(1)) lstate_q <= L_DONE;
				end
				L_DONE: begin
					lstate_q <= L_IDLE;
				end
			endcase
		end
	end

	// datapath: the upper part of the product is already below den, so only
	// the low QUO_BITS bits need shifting through
	always_ff @(posedge clk) begin
		unique case (lstate_q)
			L_IDLE: begin
				if (req.go) begin
					prod_s1    <= mag * req.num;
					neg_q      <= dlt[mti_pkg::MAG_BITS-1];
					from_end_q <= req.from_end;
					den_q      <= req.den;
				end
			end
			L_LOAD: begin
				rem_q <= prod_s1[mti_pkg::QUO_BITS +: mti_pkg::DEN_BITS];
				quo_q <= prod_s1[mti_pkg::QUO_BITS-1:0];
			end
			L_DIV: begin
				rem_q <= take ? trial_sub[mti_pkg::DEN_BITS-1:0]
					: trial[mti_pkg::DEN_BITS-1:0];
				quo_q <= {quo_q[mti_pkg::QUO_BITS-2:0], take};
			end
			L_DONE: begin
			end
		endcase
	end

	assign q_ext = {1'b0, quo_q};
	assign offs  = neg_q ? (~q_ext + 1'b1) : q_ext;

	assign rsp.done = (lstate_q == L_DONE);
	assign rsp.pos  = from_end_q
		? (end_pos - $signed(offs[mti_pkg::COORD_BITS-1:0]))
		: (start_pos + $signed(offs[mti_pkg::COORD_BITS-1:0]));

endmodule

// File: hdl/motion_tween_interpolator.sv
// ----------------------------------------------------------------------------
// motion_tween_interpolator: two-axis sprite position tween
// Tick and move words in, one position word out per input word.
// ----------------------------------------------------------------------------
// Path: a running tween goes through ST_EVAL, ST_SQR, ST_WAIT (the
//   17-step restoring divider in each axis lane) and ST_OUT; when the sprite is
//   still or snaps to its target on this word, ST_EVAL goes straight to ST_OUT.
// Throughput: one word at a time; the next word is taken the cycle after the
//   result enters the output register.
// Reset: arst_n clears position, target, span, elapsed count and mode to 0.
module motion_tween_interpolator (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// dest_x, dest_y, duration_ticks, move_mode, zero fill
	input  logic [mti_pkg::IN_DATA_BITS-1:0]   s_tdata,
	// command
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// pos_x, pos_y, moving, zero fill
	output logic [mti_pkg::OUT_DATA_BITS-1:0]  m_tdata
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EVAL = 5'b00010,
		ST_SQR  = 5'b00100,
		ST_WAIT = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	localparam int C = mti_pkg::COORD_BITS;
	localparam int T = mti_pkg::TIME_BITS;

	state_t                  state_q;
	logic signed [C-1:0]     start_x_q, start_y_q, target_x_q, target_y_q;
	logic [T-1:0]            span_q, elapsed_q;
	mti_pkg::mode_t          mode_q;

	logic                    cmd_q;
	logic signed [C-1:0]     dest_x_q, dest_y_q;
	logic [T-1:0]            dur_q;
	mti_pkg::mode_t          new_mode_q;

	logic [T-1:0]            u_s1;
	logic                    from_end_s1;
	logic                    go_s2;
	logic [mti_pkg::NUM_BITS-1:0] num_s2;
	logic [mti_pkg::DEN_BITS-1:0] den_s2;
	logic                    from_end_s2;

	logic signed [C-1:0]     res_x_q, res_y_q;
	logic                    m_tvalid_q;
	logic signed [C-1:0]     out_x_q, out_y_q;
	logic                    out_moving_q;

	logic                    s_fire;
	logic                    snap;
	logic                    late_half;
	logic [mti_pkg::DEN_BITS-1:0] u_sq;
	logic [mti_pkg::DEN_BITS-1:0] span_sq;
	logic                    out_free;

	mti_pkg::lane_req_t      req;
	mti_pkg::lane_rsp_t      rsp_x, rsp_y;

	assign s_tready = (state_q == ST_IDLE);
	assign s_fire   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign snap      = (mode_q != mti_pkg::MODE_HOLD) && (elapsed_q >= span_q);
	assign late_half = ({elapsed_q, 1'b0} > {1'b0, span_q});
	assign u_sq      = u_s1 * u_s1;
	assign span_sq   = span_q * span_q;

	assign req.go       = go_s2;
	assign req.num      = num_s2;
	assign req.den      = den_s2;
	assign req.from_end = from_end_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			start_x_q  <= '0;
			start_y_q  <= '0;
			target_x_q <= '0;
			target_y_q <= '0;
			span_q     <= '0;
			elapsed_q  <= '0;
			mode_q     <= mti_pkg::MODE_HOLD;
			go_s2      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			go_s2 <= 1'b0;
			if (m_tready) m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						// elapsed saturates and stands still while holding
						if (s_tuser == mti_pkg::CMD_TICK && mode_q != mti_pkg::MODE_HOLD
							&& elapsed_q != {T{1'b1}}) begin
							elapsed_q <= elapsed_q + 1'b1;
						end
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (snap) begin
						mode_q    <= mti_pkg::MODE_HOLD;
						start_x_q <= target_x_q;
						start_y_q <= target_y_q;
					end
					if (snap || mode_q == mti_pkg::MODE_HOLD) state_q <= ST_OUT;
					else state_q <= ST_SQR;
				end
				ST_SQR: begin
					go_s2   <= 1'b1;
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (rsp_x.done && rsp_y.done) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						if (cmd_q == mti_pkg::CMD_MOVE) begin
							start_x_q  <= res_x_q;
							start_y_q  <= res_y_q;
							target_x_q <= dest_x_q;
							target_y_q <= dest_y_q;
							span_q     <= dur_q;
							elapsed_q  <= '0;
							mode_q     <= new_mode_q;
						end
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			cmd_q      <= s_tuser;
			dest_x_q   <= s_tdata[mti_pkg::DX_LSB +: C];
			dest_y_q   <= s_tdata[mti_pkg::DY_LSB +: C];
			dur_q      <= s_tdata[mti_pkg::DUR_LSB +: T];
			new_mode_q <= mti_pkg::mode_t'(s_tdata[mti_pkg::MODE_LSB +: 2]);
		end
		if (state_q == ST_EVAL) begin
			res_x_q <= snap ? target_x_q : start_x_q;
			res_y_q <= snap ? target_y_q : start_y_q;
			// second half of ease-in-out mirrors from the target
			if (mode_q == mti_pkg::MODE_EASE_IN_OUT && late_half) begin
				u_s1        <= span_q - elapsed_q;
				from_end_s1 <= 1'b1;
			end else begin
				u_s1        <= elapsed_q;
				from_end_s1 <= 1'b0;
			end
		end
		if (state_q == ST_SQR) begin
			from_end_s2 <= from_end_s1;
			unique case (mode_q)
				mti_pkg::MODE_HOLD, mti_pkg::MODE_LINEAR: begin
					num_s2 <= mti_pkg::NUM_BITS'(elapsed_q);
					den_s2 <= mti_pkg::DEN_BITS'(span_q);
				end
				mti_pkg::MODE_EASE_IN: begin
					num_s2 <= mti_pkg::NUM_BITS'(u_sq);
					den_s2 <= span_sq;
				end
				mti_pkg::MODE_EASE_IN_OUT: begin
					num_s2 <= {u_sq, 1'b0};
					den_s2 <= span_sq;
				end
			endcase
		end
		if (state_q == ST_WAIT && rsp_x.done && rsp_y.done) begin
			res_x_q <= rsp_x.pos;
			res_y_q <= rsp_y.pos;
		end
		// merge both lanes into the output word
		if (state_q == ST_OUT && out_free) begin
			out_x_q      <= res_x_q;
			out_y_q      <= res_y_q;
			out_moving_q <= (cmd_q == mti_pkg::CMD_MOVE) ? (new_mode_q != mti_pkg::MODE_HOLD)
				: (mode_q != mti_pkg::MODE_HOLD);
		end
	end

	mti_lane u_lane_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.start_pos (start_x_q),
		.end_pos   (target_x_q),
		.rsp       (rsp_x)
	);

	mti_lane u_lane_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.start_pos (start_y_q),
		.end_pos   (target_y_q),
		.rsp       (rsp_y)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = mti_pkg::OUT_DATA_BITS'({out_moving_q, out_y_q, out_x_q});

endmodule

// File: hdl/mti_checker.sv
// ----------------------------------------------------------------------------
// mti_checker: port-level checks for the motion tween interpolator
// Tracks words in flight and checks stream behavior over time.
// ----------------------------------------------------------------------------
module mti_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	input  logic                               s_tready,
	input  logic                               m_tvalid,
	input  logic                               m_tready,
	input  logic [mti_pkg::OUT_DATA_BITS-1:0]  m_tdata
);

	logic [1:0] pend_q;
	logic       s_fire;
	logic       m_fire;

	assign s_fire = s_tvalid && s_tready;
	assign m_fire = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
		end else begin
			pend_q <= pend_q + {1'b0, s_fire} - {1'b0, m_fire};
		end
	end

	// one word is worked on at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> !s_tready)
		else $error("input accepted while a word is still in work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output word changed");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 2'd0)
		else $error("output word without an accepted input word");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two words in flight");

endmodule

bind motion_tween_interpolator mti_checker u_mti_checker (.*);

// File: tb/sv/motion_tween_interpolator_tb.sv
// ----------------------------------------------------------------------------
// motion_tween_interpolator_tb: self-checking bench for the sprite tween
// Drives tick and move words with random gaps and output stalls, predicts
// every position word from an in-bench copy of the tween state and compares
// each result word in order.
// ----------------------------------------------------------------------------
module motion_tween_interpolator_tb;

	localparam int QUIET_LIMIT = 1000;

	typedef struct packed {
		logic signed [mti_pkg::COORD_BITS-1:0] x;
		logic signed [mti_pkg::COORD_BITS-1:0] y;
		logic                                  moving;
	} sprite_pos_t;

	logic                              clk;
	logic                              arst_n;
	logic                              s_tvalid;
	logic                              s_tready;
	logic [mti_pkg::IN_DATA_BITS-1:0]  s_tdata;
	logic                              s_tuser;
	logic                              m_tvalid;
	logic                              m_tready;
	logic [mti_pkg::OUT_DATA_BITS-1:0] m_tdata;

	motion_tween_interpolator DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// tween state tracked by the bench
	logic signed [mti_pkg::COORD_BITS-1:0] cur_x = '0;
	logic signed [mti_pkg::COORD_BITS-1:0] cur_y = '0;
	logic signed [mti_pkg::COORD_BITS-1:0] goal_x = '0;
	logic signed [mti_pkg::COORD_BITS-1:0] goal_y = '0;
	logic [mti_pkg::TIME_BITS-1:0]         span_q = '0;
	logic [mti_pkg::TIME_BITS-1:0]         elapsed_q = '0;
	mti_pkg::mode_t                        mode_q = mti_pkg::MODE_HOLD;

	sprite_pos_t pos_expect_q[$];
	int          err_cnt = 0;
	int          words_sent = 0;
	int          quiet_cycles = 0;
	bit          idle_en = 1'b1;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// trunc toward zero of d * k * num / den
	function automatic longint scaled_offset(longint d, longint unsigned k,
			longint unsigned num, longint unsigned den);
		longint unsigned mag, q;
		mag = (d < 0) ? longint'(-d) : longint'(d);
		q = (mag * k * num) / den;
		return (d < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic signed [mti_pkg::COORD_BITS-1:0] axis_pos(
			logic signed [mti_pkg::COORD_BITS-1:0] s,
			logic signed [mti_pkg::COORD_BITS-1:0] e);
		longint          d, r;
		longint unsigned t, dd;
		d = longint'(e) - longint'(s);
		t = elapsed_q;
		dd = span_q;
		case (mode_q)
			mti_pkg::MODE_LINEAR: r = s + scaled_offset(d, 1, t, dd);
			mti_pkg::MODE_EASE_IN: r = s + scaled_offset(d, 1, t * t, dd * dd);
			default: begin
				if (2 * t <= dd)
					r = s + scaled_offset(d, 2, t * t, dd * dd);
				else
					r = e - scaled_offset(d, 2, (dd - t) * (dd - t), dd * dd);
			end
		endcase
		return r[mti_pkg::COORD_BITS-1:0];
	endfunction

	// snaps to the target once elapsed reaches the span
	function automatic void settle_pos(output logic signed [mti_pkg::COORD_BITS-1:0] px,
			output logic signed [mti_pkg::COORD_BITS-1:0] py);
		if (mode_q != mti_pkg::MODE_HOLD && elapsed_q >= span_q) begin
			mode_q = mti_pkg::MODE_HOLD;
			cur_x = goal_x;
			cur_y = goal_y;
		end
		if (mode_q == mti_pkg::MODE_HOLD) begin
			px = cur_x;
			py = cur_y;
		end else begin
			px = axis_pos(cur_x, goal_x);
			py = axis_pos(cur_y, goal_y);
		end
	endfunction

	function automatic sprite_pos_t predict_pos(logic cmd,
			logic [mti_pkg::IN_DATA_BITS-1:0] data);
		sprite_pos_t                           r;
		logic signed [mti_pkg::COORD_BITS-1:0] px, py;
		if (cmd == mti_pkg::CMD_MOVE) begin
			settle_pos(px, py);
			cur_x = px;
			cur_y = py;
			goal_x = data[mti_pkg::DX_LSB +: mti_pkg::COORD_BITS];
			goal_y = data[mti_pkg::DY_LSB +: mti_pkg::COORD_BITS];
			span_q = data[mti_pkg::DUR_LSB +: mti_pkg::TIME_BITS];
			elapsed_q = '0;
			mode_q = mti_pkg::mode_t'(data[mti_pkg::MODE_LSB +: 2]);
		end else begin
			if (mode_q != mti_pkg::MODE_HOLD && elapsed_q != '1)
				elapsed_q = elapsed_q + 1'b1;
			settle_pos(px, py);
		end
		r.x = px;
		r.y = py;
		r.moving = (mode_q != mti_pkg::MODE_HOLD);
		return r;
	endfunction

	task automatic log_fault(input string msg);
		err_cnt++;
		if (err_cnt <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	always @(posedge clk) begin : word_monitor
		sprite_pos_t want, got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.x = m_tdata[mti_pkg::DX_LSB +: mti_pkg::COORD_BITS];
				got.y = m_tdata[mti_pkg::DY_LSB +: mti_pkg::COORD_BITS];
				got.moving = m_tdata[mti_pkg::MOV_BIT];
				if (pos_expect_q.size() == 0) begin
					log_fault($sformatf("unexpected word x=%0d y=%0d moving=%0b",
						got.x, got.y, got.moving));
				end else begin
					want = pos_expect_q.pop_front();
					if (got.x !== want.x)
						log_fault($sformatf("pos_x exp %0d got %0d", want.x, got.x));
					if (got.y !== want.y)
						log_fault($sformatf("pos_y exp %0d got %0d", want.y, got.y));
					if (got.moving !== want.moving)
						log_fault($sformatf("moving exp %0b got %0b", want.moving, got.moving));
				end
			end
			if (s_tvalid && s_tready)
				pos_expect_q.push_back(predict_pos(s_tuser, s_tdata));
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	// output side back-pressure
	initial begin : ready_gen
		int n;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (idle_en && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				n = $urandom_range(1, 18);
				repeat (n - 1) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		wait (arst_n === 1'b1);
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	// valid stays high after a word is taken; the next call replaces or drops it
	task automatic send_word(input logic cmd, input logic [mti_pkg::COORD_BITS-1:0] dx,
			input logic [mti_pkg::COORD_BITS-1:0] dy,
			input logic [mti_pkg::TIME_BITS-1:0] dur, input logic [1:0] mode);
		logic [mti_pkg::IN_DATA_BITS-1:0] w;
		if (idle_en && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		w = '0;
		w[mti_pkg::DX_LSB +: mti_pkg::COORD_BITS] = dx;
		w[mti_pkg::DY_LSB +: mti_pkg::COORD_BITS] = dy;
		w[mti_pkg::DUR_LSB +: mti_pkg::TIME_BITS] = dur;
		w[mti_pkg::MODE_LSB +: 2] = mode;
		s_tvalid <= 1'b1;
		s_tdata <= w;
		s_tuser <= cmd;
		do @(posedge clk); while (!s_tready);
		words_sent++;
	endtask

	task automatic send_move(input logic [mti_pkg::COORD_BITS-1:0] dx,
			input logic [mti_pkg::COORD_BITS-1:0] dy,
			input logic [mti_pkg::TIME_BITS-1:0] dur, input mti_pkg::mode_t mode);
		send_word(mti_pkg::CMD_MOVE, dx, dy, dur, mode);
	endtask

	// unused fields carry junk on a tick
	task automatic send_tick();
		logic [31:0] r1, r2;
		r1 = $urandom;
		r2 = $urandom;
		send_word(mti_pkg::CMD_TICK, r1[15:0], r1[31:16], r2[15:0], r2[17:16]);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pos_expect_q.size() != 0) @(posedge clk);
	endtask

	function automatic logic [mti_pkg::COORD_BITS-1:0] rand_coord();
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			default: return mti_pkg::COORD_BITS'($urandom);
		endcase
	endfunction

	// mostly short spans so tweens run to the snap
	function automatic logic [mti_pkg::TIME_BITS-1:0] rand_span();
		case ($urandom_range(0, 15))
			0: return mti_pkg::TIME_BITS'($urandom);
			1, 2, 3: return mti_pkg::TIME_BITS'($urandom_range(13, 40));
			default: return mti_pkg::TIME_BITS'($urandom_range(0, 12));
		endcase
	endfunction

	task automatic test_reset_state();
		send_tick();
		send_tick();
	endtask

	task automatic test_linear_extremes();
		send_move(16'h7FFF, 16'h8000, 16'd4, mti_pkg::MODE_LINEAR);
		repeat (4) send_tick();
		send_move(16'h8000, 16'h7FFF, 16'd3, mti_pkg::MODE_LINEAR);
		send_tick();
	endtask

	task automatic test_eased_modes();
		// move lands mid-tween and reports the partial position
		send_move(16'h8000, 16'h8000, 16'd5, mti_pkg::MODE_EASE_IN);
		repeat (2) send_tick();
		send_move(16'h7FFF, 16'h7FFF, 16'hFFFF, mti_pkg::MODE_EASE_IN_OUT);
		send_tick();
		send_move(16'h0000, 16'h0000, 16'd5, mti_pkg::MODE_EASE_IN_OUT);
		repeat (6) send_tick();
	endtask

	task automatic test_hold_and_zero_span();
		send_move(16'd100, -16'sd100, 16'd50, mti_pkg::MODE_HOLD);
		send_tick();
		send_move(-16'sd5, 16'd9, 16'd0, mti_pkg::MODE_LINEAR);
		send_tick();
		send_move(16'd1, 16'd2, 16'd0, mti_pkg::MODE_EASE_IN_OUT);
		send_move(16'd3, 16'd4, 16'd2, mti_pkg::MODE_EASE_IN);
	endtask

	task automatic test_random_tweens(input int n_words);
		int                            stop_at, n_ticks, pick;
		logic [mti_pkg::TIME_BITS-1:0] dur;
		stop_at = words_sent + n_words;
		while (words_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 85) begin
				dur = rand_span();
				send_move(rand_coord(), rand_coord(), dur,
					mti_pkg::mode_t'($urandom_range(0, 3)));
				if (dur > 40)
					n_ticks = $urandom_range(1, 6);
				else if ($urandom_range(0, 3) == 0)
					n_ticks = $urandom_range(0, dur);
				else
					n_ticks = dur + $urandom_range(0, 2);
				repeat (n_ticks) send_tick();
			end else if (pick < 93) begin
				send_move(rand_coord(), rand_coord(), rand_span(),
					mti_pkg::mode_t'($urandom_range(0, 3)));
			end else begin
				repeat ($urandom_range(1, 3)) send_tick();
			end
		end
	endtask

	task automatic test_paused_sender();
		test_random_tweens(30);
		wait_drained();
		test_random_tweens(30);
	endtask

	initial begin
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= mti_pkg::CMD_TICK;
		arst_n <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_linear_extremes();
		test_eased_modes();
		test_hold_and_zero_span();
		test_random_tweens(880);
		test_paused_sender();
		idle_en = 1'b0;
		test_random_tweens(330);
		wait_drained();
		repeat (40) @(posedge clk);
		if (err_cnt == 0 && pos_expect_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
